// ===== rtl/core/alld_pkg.sv =====
// shared types and constants of the addressable led line driver
package alld_pkg;

    localparam int LED_COUNT  = 64;
    localparam int PIX_W      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int COLOR_W    = 8;
    localparam int WORD_W     = 3 * COLOR_W;
    localparam int INDEX_W    = 8;
    localparam int PULSE_W    = 10;
    localparam int TICK_W     = 20;
    localparam int BIT_CNT_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [PIX_W-1:0]     PIX_LAST = PIX_W'(LED_COUNT - 1);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(WORD_W - 1);
    localparam logic [INDEX_W:0]     LED_LIMIT = (INDEX_W + 1)'(LED_COUNT);

    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_GAP = 3'd4;

    localparam logic [PULSE_W-1:0] RST_ONE_HIGH  = 10'd18;
    localparam logic [PULSE_W-1:0] RST_ONE_LOW   = 10'd7;
    localparam logic [PULSE_W-1:0] RST_ZERO_HIGH = 10'd7;
    localparam logic [PULSE_W-1:0] RST_ZERO_LOW  = 10'd18;
    localparam logic [TICK_W-1:0]  RST_LATCH_GAP = 20'd5600;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_FILL,
        CMD_REFRESH,
        CMD_TICK
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_LATCH
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FILL
    } t_ctrl_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic fill_step;
    } t_dp_cmd;

    typedef struct packed {
        logic start_fill;
        logic fill_last;
    } t_dp_sts;

endpackage

// ===== rtl/core/alld_in_if.sv =====
// command channel of the addressable led line driver
interface alld_in_if import alld_pkg::*;;
    logic                 valid;
    logic                 ready;
    t_cmd                 command;
    logic [INDEX_W-1:0]   led_index;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;

    modport source (output valid, command, led_index, red, green, blue, input ready);
    modport sink (input valid, command, led_index, red, green, blue, output ready);
endinterface

// ===== rtl/core/alld_out_if.sv =====
// result channel of the addressable led line driver
interface alld_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic rejected;

    modport source (output valid, line_level, busy_res, rejected, input ready);
    modport sink (input valid, line_level, busy_res, rejected, output ready);
endinterface

// ===== rtl/core/alld_ctrl.sv =====
// controller: sequences capture, execute and fill sweep, owns the handshakes
module alld_ctrl import alld_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_ctrl_state r_state, n_state;
    logic        r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.exec      = 1'b0;
        o_cmd.fill_step = 1'b0;
        n_out_valid     = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // result slot must be free before the state commits
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = i_sts.start_fill ? S_FILL : S_IDLE;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/alld_datapath.sv =====
// datapath: config registers, pixel store, waveform counters and result register
module alld_datapath import alld_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                  i_command,
    input  logic [INDEX_W-1:0]    i_led_index,
    input  logic [COLOR_W-1:0]    i_red,
    input  logic [COLOR_W-1:0]    i_green,
    input  logic [COLOR_W-1:0]    i_blue,
    output logic                  o_line_level,
    output logic                  o_busy_res,
    output logic                  o_rejected
);

    logic [PULSE_W-1:0] r_one_high, r_one_low, r_zero_high, r_zero_low;
    logic [TICK_W-1:0]  r_latch_gap;

    t_cmd               r_command;
    logic [INDEX_W-1:0] r_led_index;
    logic [WORD_W-1:0]  r_word;

    logic [WORD_W-1:0]  r_mem [LED_COUNT];
    logic [LED_COUNT-1:0] r_valid;
    logic [WORD_W-1:0]  r_rd_word;
    logic               r_rd_valid;
    logic [PIX_W-1:0]   rd_addr, wr_addr, r_fill_addr;
    logic               mem_we, wr_pix;

    t_phase                r_phase, n_phase;
    logic                  r_dirty, n_dirty;
    logic [PIX_W-1:0]      r_pix_cnt, n_pix_cnt;
    logic [BIT_CNT_W-1:0]  r_bit_cnt, n_bit_cnt;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [WORD_W-1:0]     r_shift, n_shift;
    logic                  r_line, r_busy, r_rej;

    logic                  busy, rej, idx_ok, start_fill;
    logic [WORD_W-1:0]     pix, ld_shift, nx_shift;
    logic [TICK_W-1:0]     ld_tick, nx_tick, low_tick;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_high  <= RST_ONE_HIGH;
            r_one_low   <= RST_ONE_LOW;
            r_zero_high <= RST_ZERO_HIGH;
            r_zero_low  <= RST_ZERO_LOW;
            r_latch_gap <= RST_LATCH_GAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ONE_HIGH:  r_one_high  <= i_cfg_data[PULSE_W-1:0];
                CFG_ONE_LOW:   r_one_low   <= i_cfg_data[PULSE_W-1:0];
                CFG_ZERO_HIGH: r_zero_high <= i_cfg_data[PULSE_W-1:0];
                CFG_ZERO_LOW:  r_zero_low  <= i_cfg_data[PULSE_W-1:0];
                CFG_LATCH_GAP: r_latch_gap <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // captured item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command   <= i_command;
            r_led_index <= i_led_index;
            r_word      <= {i_red, i_green, i_blue};
        end
    end

    // pixel store, read on capture, written on execute or fill sweep
    assign rd_addr = (i_command == CMD_REFRESH) ? '0 : r_pix_cnt + 1'b1;
    assign wr_addr = i_cmd.fill_step ? r_fill_addr : r_led_index[PIX_W-1:0];
    assign mem_we  = (i_cmd.exec && wr_pix) || i_cmd.fill_step;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_word  <= r_mem[rd_addr];
            r_rd_valid <= r_valid[rd_addr];
        end
        if (mem_we) begin
            r_mem[wr_addr] <= r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (mem_we) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_addr <= '0;
        end else if (i_cmd.exec) begin
            r_fill_addr <= '0;
        end else if (i_cmd.fill_step) begin
            r_fill_addr <= r_fill_addr + 1'b1;
        end
    end

    // never written entries read as zero
    assign pix      = r_rd_valid ? r_rd_word : '0;
    assign ld_shift = {pix[15:8], pix[23:16], pix[7:0]};
    assign ld_tick  = TICK_W'(ld_shift[WORD_W-1] ? r_one_high : r_zero_high);
    assign nx_shift = {r_shift[WORD_W-2:0], 1'b0};
    assign nx_tick  = TICK_W'(r_shift[WORD_W-2] ? r_one_high : r_zero_high);
    assign low_tick = TICK_W'(r_shift[WORD_W-1] ? r_one_low : r_zero_low);
    assign idx_ok   = {1'b0, r_led_index} < LED_LIMIT;
    assign busy     = r_phase != PH_IDLE;
    assign rej      = (r_command != CMD_TICK) && busy;

    always_comb begin
        n_phase    = r_phase;
        n_dirty    = r_dirty;
        n_pix_cnt  = r_pix_cnt;
        n_bit_cnt  = r_bit_cnt;
        n_tick     = r_tick;
        n_shift    = r_shift;
        wr_pix     = 1'b0;
        start_fill = 1'b0;
        if (!rej) begin
            case (r_command)
                CMD_WRITE: begin
                    n_dirty = 1'b1;
                    wr_pix  = idx_ok;
                end
                CMD_FILL: begin
                    n_dirty    = 1'b1;
                    start_fill = 1'b1;
                end
                CMD_REFRESH: begin
                    if (r_dirty) begin
                        n_pix_cnt = '0;
                        n_bit_cnt = '0;
                        n_shift   = ld_shift;
                        n_phase   = PH_HIGH;
                        n_tick    = ld_tick;
                    end
                end
                CMD_TICK: begin
                    if (busy) begin
                        if (r_tick <= TICK_W'(1)) begin
                            case (r_phase)
                                PH_HIGH: begin
                                    n_phase = PH_LOW;
                                    n_tick  = low_tick;
                                end
                                PH_LOW: begin
                                    if (r_bit_cnt != BIT_LAST) begin
                                        n_bit_cnt = r_bit_cnt + 1'b1;
                                        n_shift   = nx_shift;
                                        n_phase   = PH_HIGH;
                                        n_tick    = nx_tick;
                                    end else if (r_pix_cnt != PIX_LAST) begin
                                        n_pix_cnt = r_pix_cnt + 1'b1;
                                        n_bit_cnt = '0;
                                        n_shift   = ld_shift;
                                        n_phase   = PH_HIGH;
                                        n_tick    = ld_tick;
                                    end else begin
                                        n_phase = PH_LATCH;
                                        n_tick  = r_latch_gap;
                                    end
                                end
                                PH_LATCH: begin
                                    n_phase = PH_IDLE;
                                    n_tick  = '0;
                                    n_dirty = 1'b0;
                                end
                                default: ;
                            endcase
                        end else begin
                            n_tick = r_tick - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_dirty   <= 1'b0;
            r_pix_cnt <= '0;
            r_bit_cnt <= '0;
            r_tick    <= '0;
            r_shift   <= '0;
        end else if (i_cmd.exec) begin
            r_phase   <= n_phase;
            r_dirty   <= n_dirty;
            r_pix_cnt <= n_pix_cnt;
            r_bit_cnt <= n_bit_cnt;
            r_tick    <= n_tick;
            r_shift   <= n_shift;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_line <= n_phase == PH_HIGH;
            r_busy <= n_phase != PH_IDLE;
            r_rej  <= rej;
        end
    end

    assign o_sts.start_fill = start_fill;
    assign o_sts.fill_last  = r_fill_addr == PIX_LAST;
    assign o_line_level     = r_line;
    assign o_busy_res       = r_busy;
    assign o_rejected       = r_rej;

endmodule

// ===== rtl/core/addressable_led_line_driver.sv =====
// top level of the addressable led line driver
// a command is captured on transfer and executed once the result slot is free; its result is registered on execute
// the input is not ready for a new command until the previous one has executed
// fill all keeps the input stalled further while the store write sweep covers every entry
// synchronous active-low reset; pixel store reads as zero through per-entry valid bits
// no clearing pass after reset, commands are taken on the first cycle out of reset
module addressable_led_line_driver import alld_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    alld_in_if.sink               i_in_ch,
    alld_out_if.source            o_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;
    logic    out_valid;

    alld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out_ch.ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    alld_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_in_ch.command),
        .i_led_index  (i_in_ch.led_index),
        .i_red        (i_in_ch.red),
        .i_green      (i_in_ch.green),
        .i_blue       (i_in_ch.blue),
        .o_line_level (o_out_ch.line_level),
        .o_busy_res   (o_out_ch.busy_res),
        .o_rejected   (o_out_ch.rejected)
    );

    assign i_in_ch.ready  = in_ready;
    assign o_out_ch.valid = out_valid;

endmodule

// ===== rtl/core/alld_checker.sv =====
// port-level checker for the addressable led line driver, bound to the top level
module alld_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_line_level,
    input logic i_busy_res,
    input logic i_rejected
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    // one command at a time: no transfer right after a transfer
    a_in_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input transfer on back-to-back cycles");

    // a rejected command leaves the frame running
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_rejected |-> i_busy_res)
        else $error("rejected while idle");

    // line only high inside a frame
    a_line_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_line_level |-> i_busy_res)
        else $error("line high while idle");

endmodule

bind addressable_led_line_driver alld_checker u_alld_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_ch.valid),
    .i_in_ready   (i_in_ch.ready),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_line_level (o_out_ch.line_level),
    .i_busy_res   (o_out_ch.busy_res),
    .i_rejected   (o_out_ch.rejected)
);

// ===== dv/alld_frame_checker.sv =====
`timescale 1ns / 1ps
// transfer monitor, line waveform predictor and result comparison for the led line driver
module alld_frame_checker import alld_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    alld_in_if                    i_cmd_mon,
    alld_out_if                   i_res_mon,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_err_cnt,
    output int                    o_pending
);

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic rejected;
    } t_line_res;

    logic [PULSE_W-1:0] one_hi, one_lo, zero_hi, zero_lo;
    logic [TICK_W-1:0]  gap_len, ticks_left;
    logic [WORD_W-1:0]  pix_mem [LED_COUNT];
    logic [WORD_W-1:0]  grb_shift;
    logic               dirty;
    t_phase             wave;
    int                 pix_ptr, bit_pos;
    int                 err_cnt = 0;
    t_line_res          line_q[$];

    initial begin
        o_err_cnt  = 0;
        o_pending  = 0;
    end

    task automatic begin_high();
        wave       = PH_HIGH;
        ticks_left = grb_shift[WORD_W-1] ? TICK_W'(one_hi) : TICK_W'(zero_hi);
    endtask

    // pixels go out green, red, blue
    task automatic load_pixel();
        logic [WORD_W-1:0] w;
        w         = pix_mem[pix_ptr];
        grb_shift = {w[2*COLOR_W-1:COLOR_W], w[WORD_W-1:2*COLOR_W], w[COLOR_W-1:0]};
        bit_pos   = 0;
        begin_high();
    endtask

    always @(posedge i_clk) begin
        t_line_res got, want;
        logic      busy, rej;
        if (!i_rst_n) begin
            one_hi     = RST_ONE_HIGH;
            one_lo     = RST_ONE_LOW;
            zero_hi    = RST_ZERO_HIGH;
            zero_lo    = RST_ZERO_LOW;
            gap_len    = RST_LATCH_GAP;
            for (int i = 0; i < LED_COUNT; i++) pix_mem[i] = '0;
            dirty      = 1'b0;
            wave       = PH_IDLE;
            pix_ptr    = 0;
            bit_pos    = 0;
            ticks_left = '0;
            grb_shift  = '0;
            line_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ONE_HIGH:  one_hi  = i_cfg_data[PULSE_W-1:0];
                    CFG_ONE_LOW:   one_lo  = i_cfg_data[PULSE_W-1:0];
                    CFG_ZERO_HIGH: zero_hi = i_cfg_data[PULSE_W-1:0];
                    CFG_ZERO_LOW:  zero_lo = i_cfg_data[PULSE_W-1:0];
                    CFG_LATCH_GAP: gap_len = i_cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end

            if (i_res_mon.valid && i_res_mon.ready) begin
                got = '{i_res_mon.line_level, i_res_mon.busy_res, i_res_mon.rejected};
                if (line_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: result transfer with none expected: line %b busy %b rej %b",
                                 $realtime, got.line_level, got.busy_res, got.rejected);
                end else begin
                    want = line_q.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("%0t: result mismatch: line %b busy %b rej %b, exp %b %b %b",
                                     $realtime, got.line_level, got.busy_res, got.rejected,
                                     want.line_level, want.busy_res, want.rejected);
                    end
                end
            end

            if (i_cmd_mon.valid && i_cmd_mon.ready) begin
                busy = wave != PH_IDLE;
                rej  = 1'b0;
                if (i_cmd_mon.command != CMD_TICK && busy) begin
                    rej = 1'b1;
                end else begin
                    case (i_cmd_mon.command)
                        CMD_WRITE: begin
                            if (i_cmd_mon.led_index < LED_COUNT)
                                pix_mem[i_cmd_mon.led_index[PIX_W-1:0]] =
                                    {i_cmd_mon.red, i_cmd_mon.green, i_cmd_mon.blue};
                            dirty = 1'b1;
                        end
                        CMD_FILL: begin
                            for (int i = 0; i < LED_COUNT; i++)
                                pix_mem[i] = {i_cmd_mon.red, i_cmd_mon.green, i_cmd_mon.blue};
                            dirty = 1'b1;
                        end
                        CMD_REFRESH: begin
                            if (dirty) begin
                                pix_ptr = 0;
                                load_pixel();
                            end
                        end
                        default: begin
                            if (busy && ticks_left > 1) begin
                                ticks_left--;
                            end else if (busy) begin
                                // count ran out, next phase starts on this tick
                                case (wave)
                                    PH_HIGH: begin
                                        wave       = PH_LOW;
                                        ticks_left = grb_shift[WORD_W-1] ? TICK_W'(one_lo)
                                                                         : TICK_W'(zero_lo);
                                    end
                                    PH_LOW: begin
                                        bit_pos++;
                                        if (bit_pos < WORD_W) begin
                                            grb_shift = grb_shift << 1;
                                            begin_high();
                                        end else begin
                                            pix_ptr++;
                                            if (pix_ptr < LED_COUNT) begin
                                                load_pixel();
                                            end else begin
                                                wave       = PH_LATCH;
                                                ticks_left = gap_len;
                                            end
                                        end
                                    end
                                    PH_LATCH: begin
                                        wave       = PH_IDLE;
                                        ticks_left = '0;
                                        dirty      = 1'b0;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                    endcase
                end
                want = '{wave == PH_HIGH, wave != PH_IDLE, rej};
                line_q.push_back(want);
            end
        end
        o_err_cnt  <= err_cnt;
        o_pending  <= line_q.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// stimulus, reset and verdict for the addressable led line driver
module tb;
    import alld_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    typedef enum {
        RX_OPEN,
        RX_LIGHT,
        RX_HALF,
        RX_PERIODIC
    } t_rx_mode;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    err_cnt;
    int                    pending;
    int                    burst_left;
    logic                  steady;

    alld_in_if  cmd_ch ();
    alld_out_if res_ch ();

    addressable_led_line_driver i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_ch    (cmd_ch),
        .o_out_ch   (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    alld_frame_checker i_chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cmd_mon  (cmd_ch),
        .i_res_mon  (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_err_cnt  (err_cnt),
        .o_pending  (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin : res_sink
        t_rx_mode mode;
        int       left;
        mode = RX_OPEN;
        left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (left == 0) begin
                case ($urandom_range(0, 3))
                    0:       mode = RX_OPEN;
                    1:       mode = RX_LIGHT;
                    2:       mode = RX_HALF;
                    default: mode = RX_PERIODIC;
                endcase
                left = $urandom_range(16, 160);
            end
            left--;
            case (mode)
                RX_OPEN:  res_ch.ready <= 1'b1;
                RX_LIGHT: res_ch.ready <= $urandom_range(0, 3) != 0;
                RX_HALF:  res_ch.ready <= $urandom_range(0, 1) != 0;
                default:  res_ch.ready <= (left % 8) > 2;
            endcase
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("addressable_led_line_driver regression: fail");
        $finish;
    end

    task automatic send_cmd(input t_cmd op, input logic [INDEX_W-1:0] idx,
                            input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                            input logic [COLOR_W-1:0] b);
        if (burst_left == 0) begin
            steady = $urandom_range(0, 5) == 0;
            if (!steady) begin
                cmd_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = steady ? $urandom_range(50, 200) : $urandom_range(1, 24);
        end
        burst_left--;
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= op;
        cmd_ch.led_index <= idx;
        cmd_ch.red       <= r;
        cmd_ch.green     <= g;
        cmd_ch.blue      <= b;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
    endtask

    task automatic send_tick();
        send_cmd(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_quiet();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // drain all results before the timing registers change, frame may keep running
    task automatic finish_frame();
        wait_quiet();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic set_timing(input logic [PULSE_W-1:0] oh, input logic [PULSE_W-1:0] ol,
                              input logic [PULSE_W-1:0] zh, input logic [PULSE_W-1:0] zl,
                              input logic [TICK_W-1:0] gap, input logic junk);
        logic [CFG_DATA_W-PULSE_W-1:0] top;
        top = junk ? (CFG_DATA_W-PULSE_W)'($urandom) : '0;
        write_reg(CFG_ONE_HIGH, {top, oh});
        write_reg(CFG_ONE_LOW, {~top, ol});
        write_reg(CFG_ZERO_HIGH, {top, zh});
        write_reg(CFG_ZERO_LOW, {~top, zl});
        write_reg(CFG_LATCH_GAP, gap);
        if (junk) begin
            for (int k = 1; k <= 3; k++)
                write_reg(CFG_LATCH_GAP + CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input int tick_pct);
        int   roll;
        t_cmd op;
        send_cmd(CMD_REFRESH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(0, 99);
            if (k < n_items / 8)
                op = roll < 50 ? CMD_WRITE : roll < 58 ? CMD_FILL :
                     roll < 70 ? CMD_REFRESH : CMD_TICK;
            else if (roll < tick_pct)
                op = CMD_TICK;
            else
                op = roll % 3 == 0 ? CMD_WRITE : roll % 3 == 1 ? CMD_FILL : CMD_REFRESH;
            send_cmd(op,
                     $urandom_range(0, 3) == 0 ? 8'($urandom_range(LED_COUNT, 255))
                                               : 8'($urandom_range(0, LED_COUNT - 1)),
                     8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin : stimulus
        rst_n            <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.command   <= CMD_TICK;
        cmd_ch.led_index <= '0;
        cmd_ch.red       <= '0;
        cmd_ch.green     <= '0;
        cmd_ch.blue      <= '0;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_ONE_HIGH;
        cfg_data         <= '0;
        burst_left       = 0;
        steady           = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset timing: clean refresh, idle tick, out of range write still marks dirty
        send_cmd(CMD_REFRESH, 8'd0, 8'h00, 8'h00, 8'h00);
        send_tick();
        send_cmd(CMD_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(CMD_REFRESH, 8'd0, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_WRITE, 8'd3, 8'h11, 8'h22, 8'h33);
        send_cmd(CMD_FILL, 8'd0, 8'hAA, 8'h55, 8'hAA);
        send_cmd(CMD_REFRESH, 8'd0, 8'h00, 8'h00, 8'h00);
        repeat (4) send_tick();
        finish_frame();

        set_timing(10'd1, 10'd1, 10'd1, 10'd1, 20'd1, 1'b0);
        send_cmd(CMD_FILL, 8'd7, 8'h12, 8'h34, 8'h56);
        send_cmd(CMD_WRITE, 8'd0, 8'hFF, 8'h00, 8'hA5);
        send_cmd(CMD_WRITE, 8'd63, 8'h00, 8'hFF, 8'h5A);
        send_cmd(CMD_WRITE, 8'd1, 8'h80, 8'h01, 8'h7F);
        send_cmd(CMD_WRITE, 8'd64, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(CMD_REFRESH, 8'd0, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_WRITE, 8'd5, 8'hFF, 8'hFF, 8'hFF);
        repeat (3) send_tick();
        finish_frame();

        set_timing(10'd0, 10'd0, 10'd0, 10'd0, 20'd0, 1'b1);
        run_phase(160, 80);
        finish_frame();

        set_timing(10'd3, 10'd1, 10'd1, 10'd2, 20'd37, 1'b1);
        run_phase(160, 85);
        finish_frame();

        set_timing(10'($urandom_range(1, 4)), 10'($urandom_range(1, 4)),
                   10'($urandom_range(1, 4)), 10'($urandom_range(1, 4)),
                   20'($urandom_range(1, 200)), 1'b0);
        run_phase(160, 80);
        finish_frame();

        set_timing(10'd2, 10'd3, 10'd1, 10'd4, 20'd9, 1'b1);
        run_phase(160, 75);
        finish_frame();

        // longest one-high and zero-low pulses and latch gap, frame still running at the end
        set_timing(10'd1023, 10'd1, 10'd1, 10'd1023, 20'hFFFFF, 1'b0);
        run_phase(1250, 98);
        wait_quiet();
        repeat (8) @(posedge clk);

        if (err_cnt == 0)
            $display("addressable_led_line_driver regression: pass");
        else
            $display("addressable_led_line_driver regression: fail");
        $finish;
    end

endmodule
